// ===== rtl/rsa_pkg.sv =====
// Shared constants, register indexes and controller/datapath link types.
package rsa_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BYTE_BITS    = 8;
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 8;

    localparam logic [WORD_BITS-1:0] BYTE_MASK = WORD_BITS'(8'hff);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PUB_MOD  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PUB_EXP  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIV_MOD = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIV_EXP = CFG_IDX_BITS'(3);

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // multiplier operand selection
    localparam logic MUL_SEL_ACC = 1'b0;
    localparam logic MUL_SEL_SQR = 1'b1;

    typedef struct packed {
        logic [WORD_BITS-1:0] pub_mod;
        logic [WORD_BITS-1:0] pub_exp;
        logic [WORD_BITS-1:0] priv_mod;
        logic [WORD_BITS-1:0] priv_exp;
    } rsa_keys_t;

    typedef struct packed {
        logic load;       // latch the accepted transaction and select key
        logic red_step;   // one restoring step of value mod n
        logic red_end;    // base <= remainder, acc <= 1 mod n
        logic mul_load;   // start a modular multiply
        logic mul_sel;    // MUL_SEL_ACC: acc*base, MUL_SEL_SQR: base*base
        logic mul_step;   // one shift-and-add step
        logic mul_wb;     // write product back to acc or base
        logic exp_shift;  // exponent >>= 1
        logic out_write;  // load the result register
    } rsa_cmd_t;

    typedef struct packed {
        logic key_missing;
        logic exp_one;
        logic cnt_done;
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
    } rsa_status_t;

endpackage

// ===== rtl/rsa_req_if.sv =====
// Input transaction channel: command, value and end-of-message mark.
interface rsa_req_if;
    import rsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [WORD_BITS-1:0] data_value;
    logic                 is_last;

    modport source (output valid, output command, output data_value, output is_last,
                    input ready);
    modport sink   (input valid, input command, input data_value, input is_last,
                    output ready);
endinterface

// ===== rtl/rsa_rsp_if.sv =====
// Result transaction channel: result word, key-missing flag, end-of-message mark.
interface rsa_rsp_if;
    import rsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result_value;
    logic                 key_missing;
    logic                 is_last_out;

    modport source (output valid, output result_value, output key_missing,
                    output is_last_out, input ready);
    modport sink   (input valid, input result_value, input key_missing,
                    input is_last_out, output ready);
endinterface

// ===== rtl/rsa_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface rsa_cfg_if;
    import rsa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [WORD_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rsa_datapath.sv =====
// Modexp datapath: key select, restoring reduction, shift-and-add modular multiplier.
module rsa_datapath (
    input  logic                         clk,
    input  rsa_pkg::rsa_keys_t           keys,
    input  logic                         req_command,
    input  logic [rsa_pkg::WORD_BITS-1:0] req_data_value,
    input  logic                         req_is_last,
    input  rsa_pkg::rsa_cmd_t            cmd,
    output rsa_pkg::rsa_status_t         st,
    output logic [rsa_pkg::WORD_BITS-1:0] result_value,
    output logic                         key_missing,
    output logic                         is_last_out
);
    import rsa_pkg::*;

    // (a + b) mod m for a, b < m
    function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return sum[WORD_BITS-1:0];
    endfunction

    logic                 dec_reg,  dec_next;
    logic                 last_reg, last_next;
    logic                 miss_reg, miss_next;
    logic                 one_reg,  one_next;
    logic [WORD_BITS-1:0] val_reg,  val_next;
    logic [WORD_BITS-1:0] qsh_reg,  qsh_next;
    logic [WORD_BITS-1:0] rem_reg,  rem_next;
    logic [CNT_BITS-1:0]  cnt_reg,  cnt_next;
    logic [WORD_BITS-1:0] mod_reg,  mod_next;
    logic [WORD_BITS-1:0] exp_reg,  exp_next;
    logic [WORD_BITS-1:0] acc_reg,  acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] ma_reg,   ma_next;
    logic [WORD_BITS-1:0] mb_reg,   mb_next;
    logic [WORD_BITS-1:0] macc_reg, macc_next;
    logic                 sel_reg,  sel_next;
    logic [WORD_BITS-1:0] res_reg,  res_next;
    logic                 omiss_reg, omiss_next;
    logic                 olast_reg, olast_next;

    logic [WORD_BITS-1:0] sel_mod;
    logic [WORD_BITS-1:0] sel_exp;
    logic [WORD_BITS:0]   rem_shift;
    logic [WORD_BITS-1:0] rem_step;
    logic [WORD_BITS-1:0] res_raw;

    always_comb
    begin
        sel_mod = (req_command == CMD_DECRYPT) ? keys.priv_mod : keys.pub_mod;
        sel_exp = (req_command == CMD_DECRYPT) ? keys.priv_exp : keys.pub_exp;

        rem_shift = {rem_reg, qsh_reg[WORD_BITS-1]};
        if (rem_shift >= {1'b0, mod_reg})
            rem_shift = rem_shift - {1'b0, mod_reg};
        rem_step = rem_shift[WORD_BITS-1:0];

        res_raw = miss_reg ? '0 : (one_reg ? val_reg : acc_reg);
        if (dec_reg)
            res_raw = res_raw & BYTE_MASK;
    end

    always_comb
    begin
        dec_next   = dec_reg;
        last_next  = last_reg;
        miss_next  = miss_reg;
        one_next   = one_reg;
        val_next   = val_reg;
        qsh_next   = qsh_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mod_next   = mod_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        macc_next  = macc_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        omiss_next = omiss_reg;
        olast_next = olast_reg;

        if (cmd.load)
        begin
            dec_next  = (req_command == CMD_DECRYPT);
            last_next = req_is_last;
            mod_next  = sel_mod;
            exp_next  = sel_exp;
            miss_next = (sel_mod == '0) || (sel_exp == '0);
            one_next  = (sel_exp == WORD_BITS'(1));
            val_next  = (req_command == CMD_DECRYPT) ? req_data_value
                                                     : (req_data_value & BYTE_MASK);
            qsh_next  = (req_command == CMD_DECRYPT) ? req_data_value
                                                     : (req_data_value & BYTE_MASK);
            rem_next  = '0;
            cnt_next  = '0;
        end

        if (cmd.red_step)
        begin
            rem_next = rem_step;
            qsh_next = {qsh_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_BITS'(1);
        end

        if (cmd.red_end)
        begin
            base_next = rem_reg;
            acc_next  = (mod_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        end

        if (cmd.mul_step)
        begin
            if (mb_reg[0])
                macc_next = add_mod(macc_reg, ma_reg, mod_reg);
            ma_next = add_mod(ma_reg, ma_reg, mod_reg);
            mb_next = {1'b0, mb_reg[WORD_BITS-1:1]};
        end

        if (cmd.mul_wb)
        begin
            if (sel_reg == MUL_SEL_ACC)
                acc_next = macc_reg;
            else
                base_next = macc_reg;
        end

        // load after write-back so a square may start in the same cycle
        if (cmd.mul_load)
        begin
            sel_next  = cmd.mul_sel;
            ma_next   = (cmd.mul_sel == MUL_SEL_ACC) ? acc_reg : base_reg;
            mb_next   = base_reg;
            macc_next = '0;
        end

        if (cmd.exp_shift)
            exp_next = {1'b0, exp_reg[WORD_BITS-1:1]};

        if (cmd.out_write)
        begin
            res_next   = res_raw;
            omiss_next = miss_reg;
            olast_next = last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg   <= dec_next;
        last_reg  <= last_next;
        miss_reg  <= miss_next;
        one_reg   <= one_next;
        val_reg   <= val_next;
        qsh_reg   <= qsh_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        mod_reg   <= mod_next;
        exp_reg   <= exp_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        macc_reg  <= macc_next;
        sel_reg   <= sel_next;
        res_reg   <= res_next;
        omiss_reg <= omiss_next;
        olast_reg <= olast_next;
    end

    assign st.key_missing = miss_reg;
    assign st.exp_one     = one_reg;
    assign st.cnt_done    = (cnt_reg == CNT_BITS'(WORD_BITS - 1));
    assign st.mul_done    = (mb_reg == '0);
    assign st.exp_zero    = (exp_reg == '0);
    assign st.exp_lsb     = exp_reg[0];

    assign result_value = res_reg;
    assign key_missing  = omiss_reg;
    assign is_last_out  = olast_reg;

endmodule

// ===== rtl/rsa_ctrl.sv =====
// Modexp sequencer: reduction, square-and-multiply loop, result hand-off.
module rsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsa_pkg::rsa_status_t st,
    output rsa_pkg::rsa_cmd_t    cmd
);
    import rsa_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_RED     = 3'd2;
    localparam logic [2:0] S_RED_END = 3'd3;
    localparam logic [2:0] S_EXP     = 3'd4;
    localparam logic [2:0] S_MUL_ACC = 3'd5;
    localparam logic [2:0] S_MUL_SQR = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ovld_reg,  ovld_next;
    logic       slot_free;

    assign slot_free = !ovld_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ovld_reg;

    always_comb
    begin
        state_next = state_reg;
        ovld_next  = ovld_reg && !rsp_ready;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.key_missing || st.exp_one)
                    state_next = S_FINISH;
                else
                    state_next = S_RED;
            end
            S_RED:
            begin
                cmd.red_step = 1'b1;
                if (st.cnt_done)
                    state_next = S_RED_END;
            end
            S_RED_END:
            begin
                cmd.red_end = 1'b1;
                state_next  = S_EXP;
            end
            S_EXP:
            begin
                if (st.exp_zero)
                    state_next = S_FINISH;
                else if (st.exp_lsb)
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MUL_SEL_ACC;
                    state_next   = S_MUL_ACC;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MUL_SEL_SQR;
                    state_next   = S_MUL_SQR;
                end
            end
            S_MUL_ACC:
            begin
                if (st.mul_done)
                begin
                    cmd.mul_wb   = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MUL_SEL_SQR;
                    state_next   = S_MUL_SQR;
                end
                else
                    cmd.mul_step = 1'b1;
            end
            S_MUL_SQR:
            begin
                if (st.mul_done)
                begin
                    cmd.mul_wb    = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = S_EXP;
                end
                else
                    cmd.mul_step = 1'b1;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_write = 1'b1;
                    ovld_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// ===== rtl/rsa_modexp_cipher.sv =====
// Sequence: when the key is missing or the exponent is one the result is written
//   directly; otherwise the value is reduced mod n, then each exponent bit takes a
//   multiply if the bit is set and a square, each a shift-and-add modular multiply.
// Throughput: one transaction at a time, set by the single shared shift-and-add
//   multiplier; a new transaction is taken while the last result waits.
// Reset: rst_n asynchronous, active low; clears the sequencer and the key registers.
module rsa_modexp_cipher (
    input  logic          clk,
    input  logic          rst_n,
    rsa_req_if.sink       req,
    rsa_rsp_if.source     rsp,
    rsa_cfg_if.sink       cfg
);
    import rsa_pkg::*;

    rsa_keys_t   keys_reg;
    rsa_keys_t   keys_next;
    rsa_cmd_t    cmd;
    rsa_status_t st;
    logic        cfg_write;

    // Key registers: write only while the block is idle (not enforced by the block).
    // Writes are always accepted; an index past the last register is dropped.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        keys_next = keys_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                REG_PUB_MOD:  keys_next.pub_mod  = cfg.data;
                REG_PUB_EXP:  keys_next.pub_exp  = cfg.data;
                REG_PRIV_MOD: keys_next.priv_mod = cfg.data;
                REG_PRIV_EXP: keys_next.priv_exp = cfg.data;
                default:      keys_next = keys_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keys_reg <= '0;
        else
            keys_reg <= keys_next;
    end

    // Sequencer: accepts a transaction only from idle, walks the reduction and
    // the square-and-multiply loop, then parks the result in the output register.
    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath: holds the selected key, the running base/accumulator and the
    // result register that drives the response channel.
    rsa_datapath u_dp (
        .clk            (clk),
        .keys           (keys_reg),
        .req_command    (req.command),
        .req_data_value (req.data_value),
        .req_is_last    (req.is_last),
        .cmd            (cmd),
        .st             (st),
        .result_value   (rsp.result_value),
        .key_missing    (rsp.key_missing),
        .is_last_out    (rsp.is_last_out)
    );

    // A taken transaction leaves the input side busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input still ready right after a transaction");

    // A missing key always reports a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.key_missing) |-> (rsp.result_value == '0))
        else $error("key missing with nonzero result");

    // A new response appears only after the result register was loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.out_write))
        else $error("response valid without a result write");

    // Reduction and multiply never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.red_step && (cmd.mul_step || cmd.mul_load)))
        else $error("reduction and multiply commanded together");

endmodule
